/* rtl/core/first_fit_block_allocator_defines.svh */
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Check a property outside reset.
`define FFBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("allocator check failed");

// Check a property at every edge, reset included.
`define FFBA_ASSERT_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("allocator check failed");

`endif

/* rtl/core/ffba_pkg.sv */
// Types and constants of the first-fit block allocator.
package ffba_pkg;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_RESIZE  = 2'd2;
  localparam logic [1:0] ACT_NOP     = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  localparam int FREE_POS = 31;
  localparam int REQ_W    = 15;
  localparam int OFF_W    = 14;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_RELEASE,
    K_RESIZE,
    K_NOP
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUND,
    S_INIT,
    S_A_RD,
    S_A_CHK,
    S_A_HDR,
    S_F_RD,
    S_F_CHK,
    S_R_RD,
    S_R_CHK,
    S_R_WR,
    S_DONE
  } state_t;

endpackage

/* rtl/core/first_fit_block_allocator.sv */
// First-fit block allocator: header memory, chain walker and request sequencer.
// Each header visited takes a read state and a check state; headers are written back for heap
// build, allocation and merge; a null request goes straight to the result; a held result stalls.
// One request at a time: the next is accepted only after the result is loaded.
// The pace is set by the single header memory, which is read one header at a time.
// Reset (synchronous) clears the sequencer, output valid and heap-ready flag; headers are kept.
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator #(
  parameter int HEAP_BYTES   = 16384,
  parameter int HEADER_BYTES = 12,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [14:0] request_bytes,
  input  logic        has_pointer,
  input  logic [13:0] payload_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [13:0] result_offset,
  output logic [14:0] copy_bytes
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int OW = AW + 2;
  localparam int CW = (OW > 17) ? OW : 17;
  localparam int NW = ffba_pkg::REQ_W + 1;
  localparam int SH = NW + $clog2(ALIGN_BYTES);
  localparam logic [NW:0] RECIP =
    (NW + 1)'(((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
  localparam logic [CW-1:0] HEAP_C  = CW'(HEAP_BYTES);
  localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] ALIGN_C = CW'(ALIGN_BYTES);

  logic [31:0] mem [HEAP_BYTES];
  logic [31:0] rdata;
  logic        we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata;

  ffba_pkg::state_t st, st_next;
  ffba_pkg::kind_t  kind;
  logic             heap_ready;
  logic [CW-1:0]    req_w, po_w, need, off, blk, old, acc, asz;
  logic             old_free;
  logic [1:0]       res_status;
  logic [CW-1:0]    res_roff, res_copy;

  logic [CW-1:0] rsize, a_next, f_next, r_acc, r_next;
  logic          rfree, fit, split, found;
  logic [NW-1:0] rnd_num;
  logic [2*NW:0] rnd_prod;
  logic [CW-1:0] rnd_need;

  assign rsize  = CW'(rdata[30:0]);
  assign rfree  = rdata[ffba_pkg::FREE_POS];
  assign fit    = rfree && (rsize >= need);
  assign split  = rsize >= need + HDR_C + ALIGN_C;
  assign a_next = off + HDR_C + rsize;
  assign f_next = a_next;
  assign found  = (off + HDR_C) == po_w;
  assign r_acc  = acc + HDR_C + rsize;
  assign r_next = blk + HDR_C + r_acc;
  assign rnd_num  = NW'(req_w) + NW'(ALIGN_BYTES - 1);
  assign rnd_prod = (2 * NW + 1)'(rnd_num) * (2 * NW + 1)'(RECIP);
  assign rnd_need = CW'(rnd_prod >> SH) * ALIGN_C;

  assign in_ready = (st == ffba_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[off[AW-1:0]];
  end

  always_comb begin
    we    = 1'b0;
    waddr = off[AW-1:0];
    wdata = {1'b0, 31'(asz)};
    unique case (st)
      ffba_pkg::S_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {1'b1, 31'(HEAP_C - HDR_C)};
      end
      ffba_pkg::S_A_CHK: begin
        we    = fit && split;
        waddr = AW'(off + HDR_C + need);
        wdata = {1'b1, 31'(rsize - need - HDR_C)};
      end
      ffba_pkg::S_A_HDR: begin
        we    = 1'b1;
        waddr = off[AW-1:0];
        wdata = {1'b0, 31'(asz)};
      end
      ffba_pkg::S_R_WR: begin
        we    = 1'b1;
        waddr = blk[AW-1:0];
        wdata = {1'b1, 31'(acc)};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ffba_pkg::S_IDLE: begin
        if (in_valid) begin
          if ((action == ffba_pkg::ACT_ALLOC && request_bytes == '0)
              || (action == ffba_pkg::ACT_RESIZE && !has_pointer && request_bytes == '0)
              || (action == ffba_pkg::ACT_RELEASE && !has_pointer)
              || action == ffba_pkg::ACT_NOP) begin
            st_next = ffba_pkg::S_DONE;
          end else begin
            st_next = ffba_pkg::S_ROUND;
          end
        end
      end
      ffba_pkg::S_ROUND: begin
        if (kind == ffba_pkg::K_ALLOC) begin
          st_next = heap_ready ? ffba_pkg::S_A_RD : ffba_pkg::S_INIT;
        end else begin
          st_next = heap_ready ? ffba_pkg::S_F_RD : ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_INIT:  st_next = ffba_pkg::S_A_RD;
      ffba_pkg::S_A_RD:  st_next = ffba_pkg::S_A_CHK;
      ffba_pkg::S_A_CHK: begin
        if (fit) begin
          st_next = ffba_pkg::S_A_HDR;
        end else if (a_next >= HEAP_C) begin
          st_next = ffba_pkg::S_DONE;
        end else begin
          st_next = ffba_pkg::S_A_RD;
        end
      end
      ffba_pkg::S_A_HDR: begin
        if (kind == ffba_pkg::K_RESIZE) begin
          st_next = (blk + HDR_C + old >= HEAP_C) ? ffba_pkg::S_R_WR : ffba_pkg::S_R_RD;
        end else begin
          st_next = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_F_RD:  st_next = ffba_pkg::S_F_CHK;
      ffba_pkg::S_F_CHK: begin
        if (found) begin
          if (kind == ffba_pkg::K_RELEASE) begin
            st_next = (f_next >= HEAP_C) ? ffba_pkg::S_R_WR : ffba_pkg::S_R_RD;
          end else if (rfree || rsize >= need) begin
            st_next = ffba_pkg::S_DONE;
          end else begin
            st_next = ffba_pkg::S_A_RD;
          end
        end else if (f_next >= HEAP_C) begin
          st_next = ffba_pkg::S_DONE;
        end else begin
          st_next = ffba_pkg::S_F_RD;
        end
      end
      ffba_pkg::S_R_RD:  st_next = ffba_pkg::S_R_CHK;
      ffba_pkg::S_R_CHK: begin
        if (rfree && r_next < HEAP_C) begin
          st_next = ffba_pkg::S_R_RD;
        end else begin
          st_next = ffba_pkg::S_R_WR;
        end
      end
      ffba_pkg::S_R_WR:  st_next = ffba_pkg::S_DONE;
      ffba_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          st_next = ffba_pkg::S_IDLE;
        end
      end
      default: st_next = ffba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ffba_pkg::S_IDLE;
      heap_ready <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ffba_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ffba_pkg::S_IDLE: begin
          res_status <= ffba_pkg::ST_NULL;
          res_roff   <= '0;
          res_copy   <= '0;
          req_w      <= CW'(request_bytes);
          po_w       <= CW'(payload_offset);
          off        <= '0;
          priority if (action == ffba_pkg::ACT_ALLOC
                       || (action == ffba_pkg::ACT_RESIZE && !has_pointer)) begin
            kind <= ffba_pkg::K_ALLOC;
          end else if (action == ffba_pkg::ACT_RELEASE
                       || (action == ffba_pkg::ACT_RESIZE && request_bytes == '0)) begin
            kind <= ffba_pkg::K_RELEASE;
          end else if (action == ffba_pkg::ACT_RESIZE) begin
            kind <= ffba_pkg::K_RESIZE;
          end else begin
            kind <= ffba_pkg::K_NOP;
          end
        end
        ffba_pkg::S_ROUND: begin
          need <= rnd_need;
          if (kind == ffba_pkg::K_RESIZE && !heap_ready) begin
            res_status <= ffba_pkg::ST_OOM;
          end
        end
        ffba_pkg::S_INIT: begin
          heap_ready <= 1'b1;
        end
        ffba_pkg::S_A_CHK: begin
          if (fit) begin
            asz <= split ? need : rsize;
          end else begin
            off <= a_next;
            if (a_next >= HEAP_C) begin
              res_status <= ffba_pkg::ST_OOM;
            end
          end
        end
        ffba_pkg::S_A_HDR: begin
          res_status <= ffba_pkg::ST_OK;
          res_roff   <= off + HDR_C;
          if (kind == ffba_pkg::K_RESIZE) begin
            res_copy <= old;
            acc      <= old;
            off      <= blk + HDR_C + old;
          end
        end
        ffba_pkg::S_F_CHK: begin
          if (found) begin
            blk      <= off;
            old      <= rsize;
            old_free <= rfree;
            if (kind == ffba_pkg::K_RELEASE) begin
              acc <= rsize;
              off <= f_next;
            end else if (rfree) begin
              res_status <= ffba_pkg::ST_OOM;
            end else if (rsize >= need) begin
              res_status <= ffba_pkg::ST_OK;
              res_roff   <= po_w;
            end else begin
              off <= '0;
            end
          end else begin
            off <= f_next;
            if (f_next >= HEAP_C && kind == ffba_pkg::K_RESIZE) begin
              res_status <= ffba_pkg::ST_OOM;
            end
          end
        end
        ffba_pkg::S_R_CHK: begin
          if (rfree) begin
            acc <= r_acc;
            off <= r_next;
          end
        end
        ffba_pkg::S_DONE: begin
          if (!out_valid || out_ready) begin
            status        <= res_status;
            result_offset <= res_roff[ffba_pkg::OFF_W-1:0];
            copy_bytes    <= res_copy[ffba_pkg::REQ_W-1:0];
          end
        end
        default: begin
          heap_ready <= heap_ready;
        end
      endcase
    end
  end

  `FFBA_ASSERT(a_accept_leaves_idle, (in_valid && in_ready) |=> (st != ffba_pkg::S_IDLE))
  `FFBA_ASSERT(a_init_sets_ready, (st == ffba_pkg::S_INIT) |=> heap_ready)
  `FFBA_ASSERT(a_ready_holds, !$fell(heap_ready))
  `FFBA_ASSERT(a_result_clean, (st == ffba_pkg::S_DONE) |->
    (res_status == ffba_pkg::ST_OK || (res_roff == '0 && res_copy == '0)))
  `FFBA_ASSERT(a_resize_live_block,
    (st == ffba_pkg::S_A_HDR && kind == ffba_pkg::K_RESIZE) |-> !old_free)

endmodule

/* sim/tb_first_fit_block_allocator.sv */
// Testbench for the first-fit block allocator: directed table, random traffic, result check.
module tb_first_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP   = 16384;
  localparam int HDR    = 12;
  localparam int ALIGN  = 8;

  typedef struct packed {
    logic [1:0]  st;
    logic [13:0] off;
    logic [14:0] cp;
  } alloc_result_t;

  typedef struct {
    logic [1:0]  act;
    logic [14:0] req;
    logic        hp;
    logic [13:0] po;
    bit          typed;
    logic [1:0]  st;
    logic [13:0] off;
    logic [14:0] cp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ffba_pkg::ACT_ALLOC;
  logic [14:0] request_bytes = '0;
  logic        has_pointer = 1'b0;
  logic [13:0] payload_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [13:0] result_offset;
  logic [14:0] copy_bytes;

  first_fit_block_allocator #(
    .HEAP_BYTES(HEAP),
    .HEADER_BYTES(HDR),
    .ALIGN_BYTES(ALIGN)
  ) u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // heap header shadow
  logic [31:0]   heap_hdr [0:HEAP-1];
  bit            heap_up;
  alloc_result_t pending_results[$];
  int            live_ptrs[$];
  int            failures;
  int            gap_left;

  function automatic int unsigned hdr_size(int unsigned o);
    return 32'(heap_hdr[o][30:0]);
  endfunction

  function automatic int unsigned round_to_align(int unsigned n);
    return ((n + ALIGN - 1) / ALIGN) * ALIGN;
  endfunction

  function automatic int chain_find(int unsigned pay);
    int unsigned o;
    o = 0;
    if (!heap_up) return -1;
    while (o < HEAP) begin
      if (o + HDR == pay) return int'(o);
      o = o + HDR + hdr_size(o);
    end
    return -1;
  endfunction

  function automatic bit carve_block(int unsigned sz, output int unsigned pay);
    int unsigned need, o, bs;
    o = 0;
    pay = 0;
    if (!heap_up) begin
      heap_hdr[0] = {1'b1, 31'(HEAP - HDR)};
      heap_up = 1'b1;
    end
    need = round_to_align(sz);
    while (o < HEAP) begin
      bs = hdr_size(o);
      if (heap_hdr[o][31] && bs >= need) begin
        if (bs >= need + HDR + ALIGN) begin
          heap_hdr[o + HDR + need] = {1'b1, 31'(bs - need - HDR)};
          bs = need;
        end
        heap_hdr[o] = {1'b0, 31'(bs)};
        pay = o + HDR;
        return 1'b1;
      end
      o = o + HDR + bs;
    end
    return 1'b0;
  endfunction

  function automatic void free_block(int unsigned o);
    int unsigned sz, nx;
    sz = hdr_size(o);
    nx = o + HDR + sz;
    while (nx < HEAP && heap_hdr[nx][31]) begin
      sz = sz + HDR + hdr_size(nx);
      nx = o + HDR + sz;
    end
    heap_hdr[o] = {1'b1, 31'(sz)};
  endfunction

  function automatic alloc_result_t allocator_step(logic [1:0] act, logic [14:0] req,
                                                   logic hp, logic [13:0] po);
    alloc_result_t r;
    int unsigned pay, old;
    int b;
    r = '{st: ffba_pkg::ST_NULL, off: '0, cp: '0};
    if (act == ffba_pkg::ACT_RESIZE && !hp) act = ffba_pkg::ACT_ALLOC;
    if (act == ffba_pkg::ACT_RESIZE && req == 0) act = ffba_pkg::ACT_RELEASE;
    case (act)
      ffba_pkg::ACT_ALLOC: begin
        if (req != 0) begin
          if (carve_block(32'(req), pay)) r = '{st: ffba_pkg::ST_OK, off: 14'(pay), cp: '0};
          else r.st = ffba_pkg::ST_OOM;
        end
      end
      ffba_pkg::ACT_RELEASE: begin
        if (hp) begin
          b = chain_find(32'(po));
          if (b >= 0) free_block(32'(b));
        end
      end
      ffba_pkg::ACT_RESIZE: begin
        b = chain_find(32'(po));
        if (b < 0 || heap_hdr[b][31]) begin
          r.st = ffba_pkg::ST_OOM;
        end else begin
          old = hdr_size(32'(b));
          if (old >= round_to_align(32'(req))) begin
            r = '{st: ffba_pkg::ST_OK, off: po, cp: '0};
          end else if (carve_block(32'(req), pay)) begin
            free_block(32'(b));
            r = '{st: ffba_pkg::ST_OK, off: 14'(pay), cp: 15'(old)};
          end else begin
            r.st = ffba_pkg::ST_OOM;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void drop_ptr(int p);
    foreach (live_ptrs[i]) begin
      if (live_ptrs[i] == p) begin
        live_ptrs.delete(i);
        return;
      end
    end
  endfunction

  task automatic send_request(stim_row_t row);
    alloc_result_t r;
    @(negedge clk);
    if (gap_left == 0 && $urandom_range(0, 9) == 0) gap_left = int'($urandom_range(1, 12));
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end
    in_valid       <= 1'b1;
    action         <= row.act;
    request_bytes  <= row.req;
    has_pointer    <= row.hp;
    payload_offset <= row.po;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = allocator_step(row.act, row.req, row.hp, row.po);
    if (row.act == ffba_pkg::ACT_RELEASE
        || (row.act == ffba_pkg::ACT_RESIZE && row.hp && row.req == 0))
      drop_ptr(int'(row.po));
    if (r.st == ffba_pkg::ST_OK) begin
      if (row.act == ffba_pkg::ACT_RESIZE && row.hp && r.off != row.po) drop_ptr(int'(row.po));
      if (!(row.act == ffba_pkg::ACT_RESIZE && r.off == row.po)) live_ptrs.push_back(int'(r.off));
    end
    if (row.typed) pending_results.push_back('{st: row.st, off: row.off, cp: row.cp});
    else pending_results.push_back(r);
  endtask

  always @(negedge clk) begin
    case ($urandom_range(0, 3))
      0: out_ready <= ($urandom_range(0, 3) != 0);
      1: out_ready <= 1'b1;
      2: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= out_ready;
    endcase
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d off=%0d copy=%0d", $time, status,
                 result_offset, copy_bytes);
        failures++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          failures++;
        end
        if (result_offset !== e.off) begin
          $display("%0t: result_offset expected %0d actual %0d", $time, e.off, result_offset);
          failures++;
        end
        if (copy_bytes !== e.cp) begin
          $display("%0t: copy_bytes expected %0d actual %0d", $time, e.cp, copy_bytes);
          failures++;
        end
      end
    end
  end

  stim_row_t directed [22] = '{
    '{ffba_pkg::ACT_RELEASE, 15'd0,     1'b0, 14'd0,     1'b1, ffba_pkg::ST_NULL, 14'd0, 15'd0},
    '{ffba_pkg::ACT_RELEASE, 15'd0,     1'b1, 14'd12,    1'b1, ffba_pkg::ST_NULL, 14'd0, 15'd0},
    '{ffba_pkg::ACT_RESIZE,  15'd40,    1'b1, 14'd12,    1'b1, ffba_pkg::ST_OOM,  14'd0, 15'd0},
    '{ffba_pkg::ACT_ALLOC,   15'd0,     1'b0, 14'd0,     1'b1, ffba_pkg::ST_NULL, 14'd0, 15'd0},
    '{ffba_pkg::ACT_RESIZE,  15'd16384, 1'b0, 14'd0,     1'b1, ffba_pkg::ST_OOM,  14'd0, 15'd0},
    '{ffba_pkg::ACT_ALLOC,   15'd1,     1'b0, 14'd0,     1'b1, ffba_pkg::ST_OK,  14'd12, 15'd0},
    '{ffba_pkg::ACT_ALLOC,   15'd8,     1'b0, 14'd0,     1'b0, ffba_pkg::ST_OK,   14'd0, 15'd0},
    '{ffba_pkg::ACT_RESIZE,  15'd0,     1'b1, 14'd12,    1'b1, ffba_pkg::ST_NULL, 14'd0, 15'd0},
    '{ffba_pkg::ACT_RESIZE,  15'd5,     1'b1, 14'd12,    1'b1, ffba_pkg::ST_OOM,  14'd0, 15'd0},
    '{ffba_pkg::ACT_RELEASE, 15'd0,     1'b1, 14'd12,    1'b1, ffba_pkg::ST_NULL, 14'd0, 15'd0},
    '{ffba_pkg::ACT_ALLOC,   15'd24,    1'b0, 14'd0,     1'b0, ffba_pkg::ST_OK,   14'd0, 15'd0},
    '{ffba_pkg::ACT_RESIZE,  15'd8,     1'b1, 14'd32,    1'b0, ffba_pkg::ST_OK,   14'd0, 15'd0},
    '{ffba_pkg::ACT_RESIZE,  15'd100,   1'b1, 14'd32,    1'b0, ffba_pkg::ST_OK,   14'd0, 15'd0},
    '{ffba_pkg::ACT_NOP,     15'h7fff,  1'b1, 14'h3fff,  1'b1, ffba_pkg::ST_NULL, 14'd0, 15'd0},
    '{ffba_pkg::ACT_RELEASE, 15'd0,     1'b1, 14'd16383, 1'b1, ffba_pkg::ST_NULL, 14'd0, 15'd0},
    '{ffba_pkg::ACT_RESIZE,  15'd10,    1'b1, 14'd5,     1'b1, ffba_pkg::ST_OOM,  14'd0, 15'd0},
    '{ffba_pkg::ACT_ALLOC,   15'd16384, 1'b0, 14'd0,     1'b1, ffba_pkg::ST_OOM,  14'd0, 15'd0},
    '{ffba_pkg::ACT_ALLOC,   15'd7000,  1'b0, 14'd0,     1'b0, ffba_pkg::ST_OK,   14'd0, 15'd0},
    '{ffba_pkg::ACT_ALLOC,   15'd7000,  1'b0, 14'd0,     1'b0, ffba_pkg::ST_OK,   14'd0, 15'd0},
    '{ffba_pkg::ACT_RESIZE,  15'd9000,  1'b1, 14'd32,    1'b0, ffba_pkg::ST_OK,   14'd0, 15'd0},
    '{ffba_pkg::ACT_ALLOC,   15'd7000,  1'b0, 14'd0,     1'b0, ffba_pkg::ST_OK,   14'd0, 15'd0},
    '{ffba_pkg::ACT_ALLOC,   15'd16372, 1'b0, 14'd0,     1'b0, ffba_pkg::ST_OK,   14'd0, 15'd0}
  };

  initial begin
    stim_row_t row;
    int pick, idx;
    failures = 0;
    gap_left = 0;
    heap_up  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_request(directed[i]);
    for (int n = 0; n < 1500; n++) begin
      row = '{ffba_pkg::ACT_ALLOC, 15'd0, 1'b0, 14'd0, 1'b0, ffba_pkg::ST_OK, 14'd0, 15'd0};
      pick = int'($urandom_range(0, 99));
      if (live_ptrs.size() > 60 && pick < 45) pick = 50;
      if (pick < 45) begin
        case ($urandom_range(0, 49))
          0:       row.req = 15'd0;
          1:       row.req = 15'd16384;
          2:       row.req = 15'($urandom_range(0, 16384));
          3, 4, 5: row.req = 15'($urandom_range(64, 1024));
          default: row.req = 15'($urandom_range(1, 96));
        endcase
        row.hp = 1'($urandom_range(0, 1));
        row.po = 14'($urandom);
      end else if (pick < 95) begin
        row.act = (pick < 75) ? ffba_pkg::ACT_RELEASE : ffba_pkg::ACT_RESIZE;
        row.hp  = 1'b1;
        idx = int'($urandom_range(0, 19));
        if (live_ptrs.size() > 0 && idx < 17)
          row.po = 14'(live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]);
        else if (idx == 17)
          row.hp = 1'b0;
        else
          row.po = 14'($urandom);
        if (row.act == ffba_pkg::ACT_RESIZE) begin
          case ($urandom_range(0, 9))
            0:       row.req = 15'd0;
            1:       row.req = 15'($urandom_range(0, 16384));
            default: row.req = 15'($urandom_range(1, 160));
          endcase
        end else begin
          row.req = 15'($urandom_range(0, 16384));
        end
      end else begin
        row.act = ffba_pkg::ACT_NOP;
        row.req = 15'($urandom);
        row.hp  = 1'($urandom_range(0, 1));
        row.po  = 14'($urandom);
      end
      send_request(row);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (failures == 0) $display("tb_first_fit_block_allocator: PASS");
    else $display("tb_first_fit_block_allocator: FAIL");
    $finish;
  end

  initial begin
    #400_000_000;
    $display("tb_first_fit_block_allocator: FAIL");
    $finish;
  end

endmodule
